/* src/gi_pkg.sv */
// ============================================================================
// gi_pkg: shared types and constants of the graph isomorphism tester
// Holds the action codes, register map, sequencer states and the control
// structs passed between the top level and the search core.
// ============================================================================
package gi_pkg;

	localparam int MAX_STATES_DEF = 16;

	localparam int SC_W = 5;
	localparam logic [SC_W-1:0] SC_RESET = 5'd16;

	localparam logic [1:0] ACT_WR_LEFT  = 2'd0;
	localparam logic [1:0] ACT_WR_RIGHT = 2'd1;
	localparam logic [1:0] ACT_TEST     = 2'd2;

	localparam logic REG_STATE_COUNT = 1'b0;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DEG_CLR,
		ST_DEG,
		ST_ORD_KEY,
		ST_ORD_SCAN,
		ST_ORD_PUT,
		ST_ENTER,
		ST_T0,
		ST_T1,
		ST_T2,
		ST_T3,
		ST_CHK,
		ST_UNDO0,
		ST_UNDO1,
		ST_BACK0,
		ST_BACK1,
		ST_BACK2,
		ST_DONE
	} gi_state_t;

	typedef struct packed {
		logic wr_left;
		logic wr_right;
		logic start;
	} gi_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic match;
	} gi_stat_t;

endpackage

/* src/gi_core.sv */
// ============================================================================
// gi_core: adjacency stores and backtracking search sequencer
// Computes degrees, orders nodes by degree and runs the depth-first pairing
// search, one small step per cycle through a shared compare datapath.
// ============================================================================
module gi_core #(
	parameter int MAX_STATES = gi_pkg::MAX_STATES_DEF,
	localparam int AW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1,
	localparam int CW = $clog2(MAX_STATES + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gi_pkg::gi_cmd_t       cmd,
	input  logic [AW-1:0]         wr_addr,
	input  logic [MAX_STATES-1:0] wr_row,
	input  logic [CW-1:0]         n_i,
	output gi_pkg::gi_stat_t      stat
);

	localparam int KW = 2 * CW;

	gi_pkg::gi_state_t state_q, state_d;

	logic [MAX_STATES-1:0] adj_l_q [MAX_STATES];
	logic [MAX_STATES-1:0] adj_r_q [MAX_STATES];
	logic [CW-1:0] din_l_q  [MAX_STATES];
	logic [CW-1:0] din_r_q  [MAX_STATES];
	logic [CW-1:0] dout_l_q [MAX_STATES];
	logic [CW-1:0] dout_r_q [MAX_STATES];
	logic [AW-1:0] ord_l_q  [MAX_STATES];
	logic [AW-1:0] ord_r_q  [MAX_STATES];
	logic [AW-1:0] stack_q  [MAX_STATES];

	logic [CW-1:0] t_q, c_q, s_q, k_q, i_q, j_q;
	logic [CW-1:0] acc_l_q, acc_r_q;
	logic [AW-1:0] rank_l_q, rank_r_q;
	logic [AW-1:0] lt_q, rt_q, tmp_q;
	logic [KW-1:0] ks_l_q, ks_r_q;
	logic [MAX_STATES-1:0] rowl_q, rowr_q;
	logic match_q;

	logic [AW-1:0] lo_addr, ro_addr, dl_addr, dr_addr, al_addr, ar_addr;
	logic [AW-1:0] lo_rd, ro_rd;
	logic [KW-1:0] key_l, key_r;
	logic [MAX_STATES-1:0] row_l, row_r;
	logic bit_l, bit_r, less_l, less_r, edge_ok;
	logic last_c, last_t, last_s;

	assign last_c = (c_q + CW'(1)) == n_i;
	assign last_t = (t_q + CW'(1)) == n_i;
	assign last_s = (s_q + CW'(1)) == n_i;

	// Read address selection: each store is read at one place per cycle.
	always_comb begin
		lo_addr = i_q[AW-1:0];
		ro_addr = k_q[AW-1:0];
		dl_addr = lt_q;
		dr_addr = rt_q;
		al_addr = lt_q;
		ar_addr = rt_q;
		unique case (state_q)
			gi_pkg::ST_T1, gi_pkg::ST_BACK1: lo_addr = k_q[AW-1:0];
			gi_pkg::ST_CHK: begin
				lo_addr = j_q[AW-1:0];
				ro_addr = j_q[AW-1:0];
			end
			default: ;
		endcase
		unique case (state_q)
			gi_pkg::ST_ORD_KEY: begin
				dl_addr = s_q[AW-1:0];
				dr_addr = s_q[AW-1:0];
			end
			gi_pkg::ST_ORD_SCAN: begin
				dl_addr = t_q[AW-1:0];
				dr_addr = t_q[AW-1:0];
			end
			default: ;
		endcase
		lo_rd = ord_l_q[lo_addr];
		ro_rd = ord_r_q[ro_addr];
		unique case (state_q)
			gi_pkg::ST_DEG: begin
				al_addr = t_q[AW-1:0];
				ar_addr = t_q[AW-1:0];
			end
			gi_pkg::ST_CHK: begin
				al_addr = lo_rd;
				ar_addr = ro_rd;
			end
			default: ;
		endcase
	end

	assign key_l  = {din_l_q[dl_addr], dout_l_q[dl_addr]};
	assign key_r  = {din_r_q[dr_addr], dout_r_q[dr_addr]};
	assign row_l  = adj_l_q[al_addr];
	assign row_r  = adj_r_q[ar_addr];
	assign bit_l  = row_l[c_q[AW-1:0]];
	assign bit_r  = row_r[c_q[AW-1:0]];
	assign less_l = (key_l < ks_l_q) || ((key_l == ks_l_q) && (t_q < s_q));
	assign less_r = (key_r < ks_r_q) || ((key_r == ks_r_q) && (t_q < s_q));
	assign edge_ok = (row_l[lt_q] == row_r[rt_q]) && (rowl_q[lo_rd] == rowr_q[ro_rd]);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gi_pkg::ST_IDLE:     if (cmd.start) state_d = gi_pkg::ST_DEG_CLR;
			gi_pkg::ST_DEG_CLR:  state_d = (n_i == '0) ? gi_pkg::ST_ENTER : gi_pkg::ST_DEG;
			gi_pkg::ST_DEG:      if (last_c && last_t) state_d = gi_pkg::ST_ORD_KEY;
			gi_pkg::ST_ORD_KEY:  state_d = gi_pkg::ST_ORD_SCAN;
			gi_pkg::ST_ORD_SCAN: if (last_t) state_d = gi_pkg::ST_ORD_PUT;
			gi_pkg::ST_ORD_PUT:  state_d = last_s ? gi_pkg::ST_ENTER : gi_pkg::ST_ORD_KEY;
			gi_pkg::ST_ENTER:    state_d = (k_q >= n_i) ? gi_pkg::ST_DONE : gi_pkg::ST_T0;
			gi_pkg::ST_T0:       state_d = (i_q >= n_i) ? gi_pkg::ST_BACK0 : gi_pkg::ST_T1;
			gi_pkg::ST_T1:       state_d = (key_l != key_r) ? gi_pkg::ST_BACK0 : gi_pkg::ST_T2;
			gi_pkg::ST_T2:       state_d = gi_pkg::ST_T3;
			gi_pkg::ST_T3:       state_d = gi_pkg::ST_CHK;
			gi_pkg::ST_CHK: begin
				if (!edge_ok) state_d = gi_pkg::ST_UNDO0;
				else if (j_q == k_q) state_d = gi_pkg::ST_ENTER;
			end
			gi_pkg::ST_UNDO0:    state_d = gi_pkg::ST_UNDO1;
			gi_pkg::ST_UNDO1:    state_d = gi_pkg::ST_T0;
			gi_pkg::ST_BACK0:    state_d = (k_q == '0) ? gi_pkg::ST_DONE : gi_pkg::ST_BACK1;
			gi_pkg::ST_BACK1:    state_d = gi_pkg::ST_BACK2;
			gi_pkg::ST_BACK2:    state_d = gi_pkg::ST_UNDO0;
			gi_pkg::ST_DONE:     state_d = gi_pkg::ST_IDLE;
			default:             state_d = gi_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		stat.busy  = (state_q != gi_pkg::ST_IDLE);
		stat.done  = (state_q == gi_pkg::ST_DONE);
		stat.match = match_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gi_pkg::ST_IDLE;
			match_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == gi_pkg::ST_ENTER && k_q >= n_i) match_q <= 1'b1;
			if (state_q == gi_pkg::ST_BACK0 && k_q == '0) match_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_left) adj_l_q[wr_addr] <= wr_row;
		if (cmd.wr_right) adj_r_q[wr_addr] <= wr_row;
		case (state_q)
			gi_pkg::ST_DEG_CLR: begin
				for (int e = 0; e < MAX_STATES; e++) begin
					din_l_q[e] <= '0;
					din_r_q[e] <= '0;
				end
				t_q <= '0;
				c_q <= '0;
				s_q <= '0;
				k_q <= '0;
				acc_l_q <= '0;
				acc_r_q <= '0;
			end
			gi_pkg::ST_DEG: begin
				din_l_q[c_q[AW-1:0]] <= din_l_q[c_q[AW-1:0]] + CW'(bit_l);
				din_r_q[c_q[AW-1:0]] <= din_r_q[c_q[AW-1:0]] + CW'(bit_r);
				if (last_c) begin
					dout_l_q[t_q[AW-1:0]] <= acc_l_q + CW'(bit_l);
					dout_r_q[t_q[AW-1:0]] <= acc_r_q + CW'(bit_r);
					acc_l_q <= '0;
					acc_r_q <= '0;
					c_q <= '0;
					t_q <= t_q + CW'(1);
				end else begin
					acc_l_q <= acc_l_q + CW'(bit_l);
					acc_r_q <= acc_r_q + CW'(bit_r);
					c_q <= c_q + CW'(1);
				end
			end
			gi_pkg::ST_ORD_KEY: begin
				ks_l_q <= key_l;
				ks_r_q <= key_r;
				t_q <= '0;
				rank_l_q <= '0;
				rank_r_q <= '0;
			end
			gi_pkg::ST_ORD_SCAN: begin
				rank_l_q <= rank_l_q + AW'(less_l);
				rank_r_q <= rank_r_q + AW'(less_r);
				t_q <= t_q + CW'(1);
			end
			gi_pkg::ST_ORD_PUT: begin
				ord_l_q[rank_l_q] <= s_q[AW-1:0];
				ord_r_q[rank_r_q] <= s_q[AW-1:0];
				s_q <= s_q + CW'(1);
			end
			gi_pkg::ST_ENTER: i_q <= k_q;
			gi_pkg::ST_T0: begin
				lt_q <= lo_rd;
				rt_q <= ro_rd;
			end
			gi_pkg::ST_T1: tmp_q <= lo_rd;
			gi_pkg::ST_T2: begin
				ord_l_q[k_q[AW-1:0]] <= lt_q;
				rowl_q <= row_l;
				rowr_q <= row_r;
			end
			gi_pkg::ST_T3: begin
				ord_l_q[i_q[AW-1:0]] <= tmp_q;
				j_q <= '0;
			end
			gi_pkg::ST_CHK: begin
				if (edge_ok && j_q == k_q) begin
					stack_q[k_q[AW-1:0]] <= i_q[AW-1:0];
					k_q <= k_q + CW'(1);
				end else begin
					j_q <= j_q + CW'(1);
				end
			end
			gi_pkg::ST_UNDO0: ord_l_q[k_q[AW-1:0]] <= tmp_q;
			gi_pkg::ST_UNDO1: begin
				ord_l_q[i_q[AW-1:0]] <= lt_q;
				i_q <= i_q + CW'(1);
			end
			gi_pkg::ST_BACK0: if (k_q != '0) k_q <= k_q - CW'(1);
			gi_pkg::ST_BACK1: begin
				i_q <= CW'(stack_q[k_q[AW-1:0]]);
				lt_q <= lo_rd;
			end
			gi_pkg::ST_BACK2: tmp_q <= lo_rd;
			default: ;
		endcase
	end

endmodule

/* src/graph_isomorphism_test.sv */
// ============================================================================
// graph_isomorphism_test: degree-pruned backtracking isomorphism tester
// Loads two directed graphs row by row and, on a test beat, answers whether
// a degree-consistent, edge-preserving node pairing exists.
// ============================================================================
//
//   channel   handshake                    payload
//   -------   --------------------------   -------------------------------
//   input     in_valid / in_stall          action, row_index, row_bits
//   output    out_valid / out_stall        isomorphic
//   config    psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// A row write beat (or an unused action) is taken back to back while idle.
// A test beat first counts degrees and orders the nodes by degree, then runs
// the search: it enters each level, tries candidates (dropping one early on a
// degree mismatch), checks edge pairs, undoes a rejected candidate, ends an
// exhausted level, steps back when needed, and finally presents the result.
// While the sequencer runs, in_stall stays high; a test beat also waits while
// an earlier result has not yet been taken on the output channel.
// Reset clears the sequencer and the output register and sets state_count to
// 16; the graph stores hold nothing meaningful until written.
module graph_isomorphism_test #(
	parameter int MAX_STATES = gi_pkg::MAX_STATES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [3:0]  row_index,
	input  logic [15:0] row_bits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        isomorphic
);

	localparam int AW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
	localparam int CW = $clog2(MAX_STATES + 1);

	logic [gi_pkg::SC_W-1:0] state_count_q;
	logic [CW-1:0] n_nodes;
	logic in_take, row_ok, reg_hit;
	logic out_valid_q, result_q;
	gi_pkg::gi_cmd_t cmd;
	gi_pkg::gi_stat_t stat;

	// The configuration port is a single register, selected when paddr bit 2 is clear.
	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == gi_pkg::REG_STATE_COUNT);
	assign prdata  = reg_hit ? 32'(state_count_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_count_q <= gi_pkg::SC_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			state_count_q <= pwdata[gi_pkg::SC_W-1:0];
		end
	end

	// A node count above the store depth saturates to the depth.
	assign n_nodes = (32'(state_count_q) > 32'(MAX_STATES)) ? CW'(MAX_STATES)
	                                                        : CW'(state_count_q);

	// A test beat needs a free result register; row writes never wait on it.
	assign in_stall = stat.busy || (action == gi_pkg::ACT_TEST && out_valid_q);
	assign in_take  = in_valid && !in_stall;
	assign row_ok   = 32'(row_index) < 32'(MAX_STATES);

	always_comb begin
		cmd.wr_left  = in_take && action == gi_pkg::ACT_WR_LEFT && row_ok;
		cmd.wr_right = in_take && action == gi_pkg::ACT_WR_RIGHT && row_ok;
		cmd.start    = in_take && action == gi_pkg::ACT_TEST;
	end

	gi_core #(
		.MAX_STATES(MAX_STATES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.wr_addr (AW'(row_index)),
		.wr_row  (MAX_STATES'(row_bits)),
		.n_i     (n_nodes),
		.stat    (stat)
	);

	// The result register holds the answer until the output beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.done) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) result_q <= stat.match;
	end

	assign out_valid  = out_valid_q;
	assign isomorphic = result_q;

`ifndef ASSERT_OFF
	a_done_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> !out_valid_q)
		else $error("search finished while the result register was full");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> stat.busy)
		else $error("test beat accepted but sequencer did not start");

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy |-> in_stall)
		else $error("input beat could be taken while the search runs");

	a_out_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_stall) |=> !out_valid_q)
		else $error("result beat presented twice");
`endif

endmodule
